@@ design/assert_macros.svh @@
// assertion helpers for the rtl, included by mr_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

@@ design/mr_pkg.sv @@
// ----------------------------------------------------------------------------
// mr_pkg
// Types and constants shared by the primality test controller and datapath.
// ----------------------------------------------------------------------------
package mr_pkg;

	localparam int NUM_PRIMES = 12;
	localparam int NUM_BASES  = 7;

	localparam logic [5:0] PRIMES [NUM_PRIMES] = '{
		6'd2, 6'd3, 6'd5, 6'd7, 6'd11, 6'd13, 6'd17, 6'd19, 6'd23, 6'd29, 6'd31, 6'd37
	};

	localparam logic [31:0] BASES [NUM_BASES] = '{
		32'd2, 32'd325, 32'd9375, 32'd28178, 32'd450775, 32'd9780504, 32'd1795265022
	};

	typedef enum logic [1:0] {
		MS_BASE_RED,
		MS_RES_BASE,
		MS_BASE_SQ,
		MS_X_SQ
	} mul_sel_t;

	typedef struct packed {
		logic     load;
		logic     trial_step;
		logic     split_init;
		logic     split_step;
		logic     round_init;
		logic     expo_shift;
		logic     k_inc;
		logic     mul_start;
		mul_sel_t mul_sel;
		logic [2:0] bidx;
	} dp_cmd_t;

	typedef struct packed {
		logic lt2;
		logic any_zero;
		logic is_small;
		logic odd_lsb;
		logic expo_zero;
		logic expo_lsb;
		logic base_zero;
		logic x_one;
		logic x_nm1;
		logic k_lt_s;
		logic mul_done;
	} dp_stat_t;

endpackage

@@ design/miller_rabin_prime_test_unit.sv @@
// ----------------------------------------------------------------------------
// miller_rabin_prime_test_unit
// Deterministic Miller-Rabin primality test of one unsigned candidate.
// ----------------------------------------------------------------------------
// A candidate is taken when start is high and busy is low; busy stays high
// until the verdict, which appears on prime_flag for one cycle with done high
// and must be captured then. One test at a time. Trial division by the primes
// 2..37 settles small or smooth values. The rest run on one shared
// shift-and-add modular multiplier; a full test needs up to seven bases times
// roughly 2*CANDIDATE_BITS products.
module miller_rabin_prime_test_unit import mr_pkg::*; #(
	parameter int CANDIDATE_BITS = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [CANDIDATE_BITS-1:0] candidate,
	output logic                      done,
	output logic                      prime_flag
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	mr_ctrl #(.W(CANDIDATE_BITS)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.done       (done),
		.prime_flag (prime_flag),
		.cmd        (cmd),
		.stat       (stat)
	);

	mr_datapath #(.W(CANDIDATE_BITS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.candidate (candidate),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

@@ design/mr_mulmod.sv @@
// ----------------------------------------------------------------------------
// mr_mulmod
// Shift-and-add modular multiplier: one doubling or one addition per cycle.
// ----------------------------------------------------------------------------
module mr_mulmod #(
	parameter int W  = 64,
	parameter int YW = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [W-1:0]  x,
	input  logic [YW-1:0] y,
	input  logic [W-1:0]  m,
	output logic          done,
	output logic [W-1:0]  result
);

	localparam int CW = $clog2(YW);

	logic [W-1:0]  acc_q;
	logic [W-1:0]  x_q;
	logic [YW-1:0] y_q;
	logic [CW-1:0] cnt_q;
	logic          phase_q;
	logic          run_q;
	logic          done_q;

	// (a + b) mod m for a, b < m
	function automatic logic [W-1:0] add_mod(input logic [W-1:0] a, input logic [W-1:0] b,
			input logic [W-1:0] md);
		logic [W-1:0] gap;
		gap = md - b;
		return (a >= gap) ? (a - gap) : (a + b);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			done_q  <= 1'b0;
			phase_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q   <= 1'b1;
				phase_q <= 1'b0;
				cnt_q   <= '0;
			end else if (run_q) begin
				phase_q <= ~phase_q;
				if (phase_q) begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(YW - 1)) begin
						run_q  <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			x_q   <= x;
			y_q   <= y;
		end else if (run_q) begin
			if (!phase_q) begin
				acc_q <= add_mod(acc_q, acc_q, m);
			end else begin
				if (y_q[YW-1]) begin
					acc_q <= add_mod(acc_q, x_q, m);
				end
				y_q <= y_q << 1;
			end
		end
	end

	assign done   = done_q;
	assign result = acc_q;

endmodule

@@ design/mr_datapath.sv @@
// ----------------------------------------------------------------------------
// mr_datapath
// Candidate, residues, exponent, base and accumulator registers around the
// shared modular multiplier.
// ----------------------------------------------------------------------------
module mr_datapath import mr_pkg::*; #(
	parameter int W = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [W-1:0] candidate,
	input  dp_cmd_t      cmd,
	output dp_stat_t     stat
);

	localparam int YW = (W > 32) ? W : 32;
	localparam int SW = $clog2(W);

	logic [W-1:0]  n_q;
	logic [W-1:0]  sh_q;
	logic [W-1:0]  odd_q;
	logic [W-1:0]  expo_q;
	logic [W-1:0]  base_q;
	logic [W-1:0]  res_q;
	logic [SW-1:0] s_q;
	logic [SW-1:0] k_q;
	logic [5:0]    rem_q [NUM_PRIMES];
	mul_sel_t      wsel_q;

	logic [W-1:0]  nm1;
	logic [W-1:0]  mx;
	logic [YW-1:0] my;
	logic          mdone;
	logic [W-1:0]  mres;
	logic          any_zero;
	logic          is_small;

	assign nm1 = n_q - 1'b1;

	always_comb begin
		mx = base_q;
		my = YW'(res_q);
		case (cmd.mul_sel)
			MS_BASE_RED: begin
				mx = W'(1);
				my = YW'(BASES[cmd.bidx]);
			end
			MS_RES_BASE: begin
				mx = base_q;
				my = YW'(res_q);
			end
			MS_BASE_SQ: begin
				mx = base_q;
				my = YW'(base_q);
			end
			default: begin
				mx = res_q;
				my = YW'(res_q);
			end
		endcase
	end

	mr_mulmod #(.W(W), .YW(YW)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.x      (mx),
		.y      (my),
		.m      (n_q),
		.done   (mdone),
		.result (mres)
	);

	always_comb begin
		any_zero = 1'b0;
		is_small = 1'b0;
		for (int i = 0; i < NUM_PRIMES; i++) begin
			if (rem_q[i] == 6'd0) any_zero = 1'b1;
			if (n_q == W'(PRIMES[i])) is_small = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q  <= candidate;
			sh_q <= candidate;
			for (int i = 0; i < NUM_PRIMES; i++) rem_q[i] <= '0;
		end
		if (cmd.trial_step) begin
			// msb-first remainder update, one bit per cycle in every lane
			for (int i = 0; i < NUM_PRIMES; i++) begin
				if ({rem_q[i], sh_q[W-1]} >= {1'b0, PRIMES[i]})
					rem_q[i] <= 6'({rem_q[i], sh_q[W-1]} - {1'b0, PRIMES[i]});
				else
					rem_q[i] <= 6'({rem_q[i], sh_q[W-1]});
			end
			sh_q <= sh_q << 1;
		end
		if (cmd.split_init) begin
			odd_q <= nm1;
			s_q   <= '0;
		end
		if (cmd.split_step) begin
			odd_q <= odd_q >> 1;
			s_q   <= s_q + 1'b1;
		end
		if (cmd.round_init) begin
			res_q  <= W'(1);
			expo_q <= odd_q;
			k_q    <= SW'(1);
		end
		if (cmd.expo_shift) expo_q <= expo_q >> 1;
		if (cmd.k_inc) k_q <= k_q + 1'b1;
		if (cmd.mul_start) wsel_q <= cmd.mul_sel;
		if (mdone) begin
			case (wsel_q)
				MS_BASE_RED, MS_BASE_SQ: base_q <= mres;
				default:                 res_q  <= mres;
			endcase
		end
	end

	assign stat.lt2       = (n_q[W-1:1] == '0);
	assign stat.any_zero  = any_zero;
	assign stat.is_small  = is_small;
	assign stat.odd_lsb   = odd_q[0];
	assign stat.expo_zero = (expo_q == '0);
	assign stat.expo_lsb  = expo_q[0];
	assign stat.base_zero = (base_q == '0);
	assign stat.x_one     = (res_q == W'(1));
	assign stat.x_nm1     = (res_q == nm1);
	assign stat.k_lt_s    = (k_q < s_q);
	assign stat.mul_done  = mdone;

endmodule

@@ design/mr_ctrl.sv @@
// ----------------------------------------------------------------------------
// mr_ctrl
// Sequencer for trial division, n-1 split and the witness rounds.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mr_ctrl import mr_pkg::*; #(
	parameter int W = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	output logic     done,
	output logic     prime_flag,
	output dp_cmd_t  cmd,
	input  dp_stat_t stat
);

	localparam int CW = $clog2(W);

	typedef enum logic [3:0] {
		S_IDLE,
		S_TRIAL,
		S_TCHK,
		S_SPLIT,
		S_BRED,
		S_BCHK,
		S_PBIT,
		S_PSQ,
		S_PSH,
		S_RCHK,
		S_SQCHK,
		S_SQRES,
		S_NEXT,
		S_MSTART,
		S_MWAIT
	} state_t;

	state_t        state_q;
	state_t        ret_q;
	mul_sel_t      msel_q;
	logic [CW-1:0] cnt_q;
	logic [2:0]    bidx_q;
	logic          done_q;
	logic          flag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			msel_q  <= MS_BASE_RED;
			cnt_q   <= '0;
			bidx_q  <= '0;
			done_q  <= 1'b0;
			flag_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cnt_q   <= '0;
						state_q <= S_TRIAL;
					end
				end
				S_TRIAL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(W - 1)) state_q <= S_TCHK;
				end
				S_TCHK: begin
					if (stat.lt2) begin
						done_q  <= 1'b1;
						flag_q  <= 1'b0;
						state_q <= S_IDLE;
					end else if (stat.any_zero) begin
						done_q  <= 1'b1;
						flag_q  <= stat.is_small;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_SPLIT;
					end
				end
				S_SPLIT: begin
					if (stat.odd_lsb) begin
						bidx_q  <= '0;
						state_q <= S_BRED;
					end
				end
				S_BRED: begin
					msel_q  <= MS_BASE_RED;
					ret_q   <= S_BCHK;
					state_q <= S_MSTART;
				end
				S_BCHK: begin
					state_q <= stat.base_zero ? S_NEXT : S_PBIT;
				end
				S_PBIT: begin
					if (stat.expo_zero) begin
						state_q <= S_RCHK;
					end else if (stat.expo_lsb) begin
						msel_q  <= MS_RES_BASE;
						ret_q   <= S_PSQ;
						state_q <= S_MSTART;
					end else begin
						state_q <= S_PSQ;
					end
				end
				S_PSQ: begin
					msel_q  <= MS_BASE_SQ;
					ret_q   <= S_PSH;
					state_q <= S_MSTART;
				end
				S_PSH: state_q <= S_PBIT;
				S_RCHK: begin
					state_q <= (stat.x_one || stat.x_nm1) ? S_NEXT : S_SQCHK;
				end
				S_SQCHK: begin
					if (stat.k_lt_s) begin
						msel_q  <= MS_X_SQ;
						ret_q   <= S_SQRES;
						state_q <= S_MSTART;
					end else begin
						done_q  <= 1'b1;
						flag_q  <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				S_SQRES: begin
					state_q <= stat.x_nm1 ? S_NEXT : S_SQCHK;
				end
				S_NEXT: begin
					if (bidx_q == 3'(NUM_BASES - 1)) begin
						done_q  <= 1'b1;
						flag_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						bidx_q  <= bidx_q + 1'b1;
						state_q <= S_BRED;
					end
				end
				S_MSTART: state_q <= S_MWAIT;
				S_MWAIT: begin
					if (stat.mul_done) state_q <= ret_q;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd            = '0;
		cmd.load       = (state_q == S_IDLE) && start;
		cmd.trial_step = (state_q == S_TRIAL);
		cmd.split_init = (state_q == S_TCHK);
		cmd.split_step = (state_q == S_SPLIT) && !stat.odd_lsb;
		cmd.round_init = (state_q == S_BCHK);
		cmd.expo_shift = (state_q == S_PSH);
		cmd.k_inc      = (state_q == S_SQRES) && !stat.x_nm1;
		cmd.mul_start  = (state_q == S_MSTART);
		cmd.mul_sel    = msel_q;
		cmd.bidx       = bidx_q;
	end

	assign busy       = (state_q != S_IDLE);
	assign done       = done_q;
	assign prime_flag = flag_q;

	`ASSERT_CLK(a_done_idle, clk, arst_n, done_q |-> state_q == S_IDLE, "result strobe outside idle")
	`ASSERT_CLK(a_mul_wait, clk, arst_n, cmd.mul_start |=> state_q == S_MWAIT, "multiply not awaited")
	`ASSERT_NEVER(a_stray_done, clk, arst_n, stat.mul_done && state_q != S_MWAIT, "stray multiply done")

endmodule
